[hdl/kld_pkg.sv]
// Package for the K-line response deframer: sizes, codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package kld_pkg;

    // Frame buffer sizing
    localparam int FRAME_MAX_BYTES = 12;
    localparam int OVERHEAD_BYTES  = 4;
    localparam int IDX_W           = $clog2(FRAME_MAX_BYTES);
    localparam int CNT_W           = $clog2(FRAME_MAX_BYTES + 1);

    // Header bytes of a response frame
    localparam logic [7:0] HDR0 = 8'h48;
    localparam logic [7:0] HDR1 = 8'h6B;

    // Timer saturation value
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P1_MAX       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P2_MIN       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P3_MIN       = 4'd3;

    // Input opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_ARM  = 2'd2;

    // Result kinds
    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_END     = 3'd1;
    localparam logic [2:0] K_NORESP  = 3'd2;
    localparam logic [2:0] K_BADHDR  = 3'd3;
    localparam logic [2:0] K_SHORT   = 3'd4;

    // Reception phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;
    localparam logic [1:0] PH_MORE  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       arm;          // clear count, sum and timer
        logic       tick;         // advance the gap timer
        logic       store;        // store the received byte
        logic       restart;      // store at the start of a new frame
        logic       clr_timer;    // clear the gap timer
        logic       close;        // latch frame checks and clear the frame
        logic       load_single;  // load a status beat
        logic       load_walk;    // load the next payload beat
        logic [2:0] kind;         // kind of the status beat
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ge_resp;      // timer reached the response timeout
        logic ge_ib;        // timer reached the inter-byte timeout
        logic ge_p3;        // timer reached the end-of-responses silence
        logic full;         // frame buffer full
        logic hdr_ok;       // latched header check of the closed frame
        logic short_frame;  // latched length check of the closed frame
        logic out_free;     // output register can take a beat
        logic walk_last;    // the next payload beat is the final one
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/kld_in_if.sv]
// Input channel of the K-line response deframer: opcode and received byte.
// Depends on kld_pkg.
`default_nettype none

interface kld_in_if import kld_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

[hdl/kld_out_if.sv]
// Result channel of the K-line response deframer.
// Depends on kld_pkg.
`default_nettype none

interface kld_out_if import kld_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] source_addr;
    logic       checksum_ok;
    logic       last;

    modport source (output valid, output kind, output payload_byte, output source_addr,
                    output checksum_ok, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input source_addr,
                    input checksum_ok, input last, output ready);
endinterface

`default_nettype wire

[hdl/kld_cfg_if.sv]
// Configuration write channel of the K-line response deframer.
// Depends on kld_pkg.
`default_nettype none

interface kld_cfg_if import kld_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/kline_response_deframer_top.sv]
// Top level of the K-line response deframer: joins the controller and the
// datapath to the input, result and configuration channels.
// Depends on kld_pkg, kld_in_if, kld_out_if, kld_cfg_if, kld_ctrl and kld_dp.
`default_nettype none

// Receives ISO 9141-2 style responses from a stream of beats: 1 ms ticks,
// received bytes and arm commands. An arm, an ignored opcode or a beat
// while idle is handled in ST_IN alone; a tick or a byte is accepted in
// ST_IN, then the timer or count compare runs in ST_CHECK. A closed frame
// passes ST_CLOSE for the header and length check, then gives one result
// beat per cycle while the output register is free: up to eight payload
// beats for a full frame of FRAME_MAX_BYTES bytes, or one status beat. The
// controller sequences one item at a time through the single output
// register, so a downstream stall holds the next input back only when a
// new result is due. The configuration channel is always ready and must be
// written only while the block is idle.

module kline_response_deframer_top import kld_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kld_in_if.sink    i_in_ch,
    kld_out_if.source o_out_ch,
    kld_cfg_if.sink   i_cfg_ch
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in_ch.ready = in_ready;

    // Sequence each beat
    kld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_opcode   (i_in_ch.opcode),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Hold frame state and drive the result channel
    kld_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_byte (i_in_ch.rx_byte),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_cfg_ch  (i_cfg_ch),
        .o_out_ch  (o_out_ch)
    );

endmodule

`default_nettype wire

[hdl/kld_dp.sv]
// Datapath of the K-line response deframer: configuration registers, frame
// buffer, counters, gap timer and the output register.
// Depends on kld_pkg, kld_out_if and kld_cfg_if.
`default_nettype none

module kld_dp import kld_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_stat       o_stat,
    kld_cfg_if.sink        i_cfg_ch,
    kld_out_if.source      o_out_ch
);

    // Configuration registers
    logic [15:0] r_resp_timeout;
    logic [7:0]  r_p1_max;
    logic [7:0]  r_p2_min;
    logic [15:0] r_p3_min;

    // Frame state
    logic [7:0]       r_store [FRAME_MAX_BYTES];
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_timer, n_timer;
    logic [7:0]       r_last_byte;

    // Closed-frame results
    logic             r_hdr_ok;
    logic             r_short;
    logic             r_ck_ok;
    logic [7:0]       r_src;
    logic [IDX_W-1:0] r_walk_idx;
    logic [IDX_W-1:0] r_walk_last;

    // Output register
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_out_kind;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_src;
    logic       r_out_ck;
    logic       r_out_last;

    logic [7:0]       p2_less2;
    logic [7:0]       ib_limit;
    logic [IDX_W-1:0] wr_addr;
    logic             out_free;

    // Inter-byte timeout: max(p2 - 2 saturated at zero, p1)
    always_comb begin
        p2_less2 = (r_p2_min >= 8'd2) ? (r_p2_min - 8'd2) : 8'd0;
        ib_limit = (p2_less2 < r_p1_max) ? r_p1_max : p2_less2;
    end

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign wr_addr  = i_cmd.restart ? '0 : r_count[IDX_W-1:0];

    // Status towards the controller
    always_comb begin
        o_stat.ge_resp     = (r_timer >= r_resp_timeout);
        o_stat.ge_ib       = (r_timer >= {8'd0, ib_limit});
        o_stat.ge_p3       = (r_timer >= r_p3_min);
        o_stat.full        = (r_count >= CNT_W'(FRAME_MAX_BYTES));
        o_stat.hdr_ok      = r_hdr_ok;
        o_stat.short_frame = r_short;
        o_stat.out_free    = out_free;
        o_stat.walk_last   = (r_walk_idx == r_walk_last);
    end

    // Next values of count, sum and timer
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_timer = r_timer;
        if (i_cmd.arm || i_cmd.close) begin
            n_count = '0;
            n_sum   = '0;
            n_timer = '0;
        end else if (i_cmd.tick) begin
            if (r_timer != TIMER_MAX) begin
                n_timer = r_timer + 16'd1;
            end
        end else if (i_cmd.store) begin
            n_count = i_cmd.restart ? CNT_W'(1) : r_count + CNT_W'(1);
            n_sum   = i_cmd.restart ? i_rx_byte : r_sum + i_rx_byte;
            n_timer = '0;
        end else if (i_cmd.clr_timer) begin
            n_timer = '0;
        end
    end

    // Output beat valid: set on load, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_single || i_cmd.load_walk) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_timeout <= 16'd100;
            r_p1_max       <= 8'd20;
            r_p2_min       <= 8'd25;
            r_p3_min       <= 16'd55;
            r_count        <= '0;
            r_sum          <= '0;
            r_timer        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_timer     <= n_timer;
            r_out_valid <= n_out_valid;
            if (i_cfg_ch.valid) begin
                case (i_cfg_ch.index)
                    REG_RESP_TIMEOUT: r_resp_timeout <= i_cfg_ch.data;
                    REG_P1_MAX:       r_p1_max       <= i_cfg_ch.data[7:0];
                    REG_P2_MIN:       r_p2_min       <= i_cfg_ch.data[7:0];
                    REG_P3_MIN:       r_p3_min       <= i_cfg_ch.data;
                    default: ;
                endcase
            end
        end
    end

    // Frame buffer, closed-frame checks and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_store[wr_addr] <= i_rx_byte;
            r_last_byte      <= i_rx_byte;
        end
        if (i_cmd.close) begin
            r_hdr_ok    <= (r_count >= CNT_W'(2)) && (r_store[0] == HDR0)
                           && (r_store[1] == HDR1);
            r_short     <= (r_count <= CNT_W'(OVERHEAD_BYTES));
            r_ck_ok     <= ((r_sum - r_last_byte) == r_last_byte);
            r_src       <= r_store[2];
            r_walk_idx  <= IDX_W'(OVERHEAD_BYTES - 1);
            r_walk_last <= IDX_W'(r_count - CNT_W'(2));
        end
        if (i_cmd.load_single) begin
            r_out_kind <= i_cmd.kind;
            r_out_byte <= 8'd0;
            r_out_src  <= 8'd0;
            r_out_ck   <= 1'b0;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_walk) begin
            r_out_kind <= K_PAYLOAD;
            r_out_byte <= r_store[r_walk_idx];
            r_out_src  <= r_src;
            r_out_ck   <= r_ck_ok;
            r_out_last <= (r_walk_idx == r_walk_last);
            r_walk_idx <= r_walk_idx + IDX_W'(1);
        end
    end

    assign i_cfg_ch.ready        = 1'b1;
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.kind         = r_out_kind;
    assign o_out_ch.payload_byte = r_out_byte;
    assign o_out_ch.source_addr  = r_out_src;
    assign o_out_ch.checksum_ok  = r_out_ck;
    assign o_out_ch.last         = r_out_last;

endmodule

`default_nettype wire

[hdl/kld_ctrl.sv]
// Controller of the K-line response deframer: reception phase, input
// handshake and the sequencing of frame checks and result beats.
// Depends on kld_pkg.
`default_nettype none

module kld_ctrl import kld_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_stat   i_stat,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd
);

    localparam logic [2:0] ST_IN     = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_CLOSE  = 3'd2;
    localparam logic [2:0] ST_SINGLE = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_byte_op, n_byte_op;
    logic [2:0] r_kind, n_kind;

    assign o_in_ready = (r_state == ST_IN);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_byte_op = r_byte_op;
        n_kind    = r_kind;
        o_cmd     = '0;
        case (r_state)
            // Take one input beat and start its work
            ST_IN: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_ARM: begin
                            o_cmd.arm = 1'b1;
                            n_phase   = PH_FIRST;
                        end
                        OP_TICK: begin
                            if (r_phase != PH_IDLE) begin
                                o_cmd.tick = 1'b1;
                                n_byte_op  = 1'b0;
                                n_state    = ST_CHECK;
                            end
                        end
                        OP_BYTE: begin
                            if (r_phase != PH_IDLE) begin
                                o_cmd.store   = 1'b1;
                                o_cmd.restart = (r_phase != PH_FRAME);
                                n_phase       = PH_FRAME;
                                n_byte_op     = 1'b1;
                                n_state       = ST_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Compare the updated timer or count against the phase limit
            ST_CHECK: begin
                n_state = ST_IN;
                case (r_phase)
                    PH_FIRST: begin
                        if (i_stat.ge_resp) begin
                            o_cmd.clr_timer = 1'b1;
                            n_phase         = PH_IDLE;
                            n_kind          = K_NORESP;
                            n_state         = ST_SINGLE;
                        end
                    end
                    PH_FRAME: begin
                        if (r_byte_op ? i_stat.full : i_stat.ge_ib) begin
                            o_cmd.close = 1'b1;
                            n_phase     = PH_MORE;
                            n_state     = ST_CLOSE;
                        end
                    end
                    PH_MORE: begin
                        if (i_stat.ge_p3) begin
                            o_cmd.clr_timer = 1'b1;
                            n_phase         = PH_IDLE;
                            n_kind          = K_END;
                            n_state         = ST_SINGLE;
                        end
                    end
                    default: ;
                endcase
            end
            // Header first, then length
            ST_CLOSE: begin
                if (!i_stat.hdr_ok) begin
                    n_kind  = K_BADHDR;
                    n_state = ST_SINGLE;
                end else if (i_stat.short_frame) begin
                    n_kind  = K_SHORT;
                    n_state = ST_SINGLE;
                end else begin
                    n_state = ST_WALK;
                end
            end
            // Hand one status beat to the output register
            ST_SINGLE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_single = 1'b1;
                    o_cmd.kind        = r_kind;
                    n_state           = ST_IN;
                end
            end
            // Walk the payload bytes out, one beat per free slot
            ST_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.load_walk = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = ST_IN;
                    end
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IN;
            r_phase   <= PH_IDLE;
            r_byte_op <= 1'b0;
            r_kind    <= K_END;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_byte_op <= n_byte_op;
            r_kind    <= n_kind;
        end
    end

endmodule

`default_nettype wire
